FILE: hw/rtl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared constants and types for the click / double click / long press
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

  // counter width default and register geometry
  localparam int COUNT_BITS_DEF = 16;
  localparam int REG_W          = 16;
  localparam int APB_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 4;
  localparam int REG_IDX_W      = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FILTER_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_LIMIT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_LOW   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_HIGH  = 2'd3;

  // reset values
  localparam logic [REG_W-1:0] FILTER_COUNT_RST = 16'd0;
  localparam logic [REG_W-1:0] LONG_LIMIT_RST   = 16'd120;
  localparam logic [REG_W-1:0] DOUBLE_LOW_RST   = 16'd10;
  localparam logic [REG_W-1:0] DOUBLE_HIGH_RST  = 16'd100;

  // event codes
  localparam int EVENT_W = 2;
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] filter_count;
    logic [REG_W-1:0] long_limit;
    logic [REG_W-1:0] double_low;
    logic [REG_W-1:0] double_high;
  } cls_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cls_if.sv
// ----------------------------------------------------------------------------
// cls_if
// Valid/ready channels: sampled key level in, classified event out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface cls_event_if
  import cls_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink   (input valid, input event_res, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cls_regs.sv
// ----------------------------------------------------------------------------
// cls_regs
// APB register bank holding the prescale limit and the three thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_regs
  import cls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cls_cfg_t                   cfg
);

  cls_cfg_t             cfg_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;
  logic [REG_W-1:0]     rd_val;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_count <= FILTER_COUNT_RST;
      cfg_r.long_limit   <= LONG_LIMIT_RST;
      cfg_r.double_low   <= DOUBLE_LOW_RST;
      cfg_r.double_high  <= DOUBLE_HIGH_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FILTER_COUNT: cfg_r.filter_count <= pwdata[REG_W-1:0];
        REG_LONG_LIMIT:   cfg_r.long_limit   <= pwdata[REG_W-1:0];
        REG_DOUBLE_LOW:   cfg_r.double_low   <= pwdata[REG_W-1:0];
        REG_DOUBLE_HIGH:  cfg_r.double_high  <= pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILTER_COUNT: rd_val = cfg_r.filter_count;
      REG_LONG_LIMIT:   rd_val = cfg_r.long_limit;
      REG_DOUBLE_LOW:   rd_val = cfg_r.double_low;
      REG_DOUBLE_HIGH:  rd_val = cfg_r.double_high;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_val);

endmodule

`default_nettype wire

FILE: hw/rtl/cls_core.sv
// ----------------------------------------------------------------------------
// cls_core
// Press classifier state and single-pass update, with a result register
// that lets a new beat in while the last result is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_core
  import cls_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cls_cfg_t   cfg,
  cls_key_if.sink    in_ch,
  cls_event_if.source out_ch
);

  localparam int CW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

  logic                  pressed_seen_r, pressed_seen_nxt;
  logic                  latched_r, latched_nxt;
  logic [COUNT_BITS-1:0] release_ticks_r, release_ticks_nxt;
  logic [COUNT_BITS-1:0] hold_ticks_r, hold_ticks_nxt;
  logic [COUNT_BITS-1:0] hold_pre_r, hold_pre_nxt;
  logic [COUNT_BITS-1:0] rel_pre_r, rel_pre_nxt;
  logic                  out_valid_r;
  logic [EVENT_W-1:0]    event_r, event_nxt;

  logic                  accept;
  logic                  released;
  logic [CW-1:0]         fc_w, ll_w, dl_w, dh_w;

  assign in_ch.ready      = ~out_valid_r | out_ch.ready;
  assign accept           = in_ch.valid & in_ch.ready;
  assign released         = in_ch.key_level;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = event_r;

  assign fc_w = CW'(cfg.filter_count);
  assign ll_w = CW'(cfg.long_limit);
  assign dl_w = CW'(cfg.double_low);
  assign dh_w = CW'(cfg.double_high);

  always_comb begin
    pressed_seen_nxt  = pressed_seen_r;
    latched_nxt       = latched_r;
    release_ticks_nxt = release_ticks_r;
    hold_ticks_nxt    = hold_ticks_r;
    hold_pre_nxt      = hold_pre_r;
    rel_pre_nxt       = rel_pre_r;
    event_nxt         = EV_NONE;

    if (latched_r) begin
      pressed_seen_nxt  = 1'b0;
      release_ticks_nxt = '0;
      hold_ticks_nxt    = '0;
      hold_pre_nxt      = '0;
      rel_pre_nxt       = '0;
      latched_nxt       = ~released;
    end

    // press only counts when no latch was in force this tick
    if (!released && !latched_r) begin
      pressed_seen_nxt = 1'b1;
      hold_pre_nxt     = hold_pre_r + 1'b1;
      if (CW'(hold_pre_nxt) > fc_w) begin
        hold_pre_nxt   = '0;
        hold_ticks_nxt = hold_ticks_r + 1'b1;
      end
    end

    if (CW'(hold_ticks_nxt) > ll_w) begin
      latched_nxt = 1'b1;
      event_nxt   = EV_LONG;
    end else begin
      if (pressed_seen_nxt && released) begin
        rel_pre_nxt = rel_pre_nxt + 1'b1;
        if (CW'(rel_pre_nxt) > fc_w) begin
          rel_pre_nxt       = '0;
          release_ticks_nxt = release_ticks_nxt + 1'b1;
        end
      end
      if (pressed_seen_nxt && CW'(release_ticks_nxt) > dl_w &&
          CW'(release_ticks_nxt) < dh_w) begin
        if (!released) begin
          latched_nxt = 1'b1;
          event_nxt   = EV_DOUBLE;
        end
      end else if (pressed_seen_nxt && CW'(release_ticks_nxt) > dh_w) begin
        latched_nxt = 1'b1;
        event_nxt   = EV_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_seen_r  <= 1'b0;
      latched_r       <= 1'b0;
      release_ticks_r <= '0;
      hold_ticks_r    <= '0;
      hold_pre_r      <= '0;
      rel_pre_r       <= '0;
      out_valid_r     <= 1'b0;
    end else if (accept) begin
      pressed_seen_r  <= pressed_seen_nxt;
      latched_r       <= latched_nxt;
      release_ticks_r <= release_ticks_nxt;
      hold_ticks_r    <= hold_ticks_nxt;
      hold_pre_r      <= hold_pre_nxt;
      rel_pre_r       <= rel_pre_nxt;
      out_valid_r     <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_r <= event_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/click_long_double_classifier.sv
// ----------------------------------------------------------------------------
// click_long_double_classifier
// Key press classifier: single click, double click or long press.
// ----------------------------------------------------------------------------
// in_ch carries one sampled key level per scan tick (0 pressed, 1 released).
// Every accepted beat yields exactly one beat on out_ch with the event code:
// none, single click, double click or long press.
// Latency: the result is presented the cycle after its input beat is taken.
// Throughput: one beat per cycle unless out_ch stalls; the counter update and
// threshold compares sit between the input handshake and the result register.
// in_ch.ready stays high while the result register is empty or being taken,
// so a stalled receiver holds the pending result and blocks only the next
// input beat.
// Reset (rst_n low, synchronous) clears all counters, the latch and the
// result valid flag, and loads the thresholds with their defaults.
// The APB port writes filter_count, long_limit, double_low and double_high
// at byte addresses 0, 4, 8 and 12; pready is always high. Write these only
// while no result is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module click_long_double_classifier
  import cls_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cls_key_if.sink                    in_ch,
  cls_event_if.source                out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cls_cfg_t cfg;

  cls_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cls_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cls_checker.sv
// ----------------------------------------------------------------------------
// cls_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_checker
  import cls_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [EVENT_W-1:0] out_event_res,
  input wire logic               pready
);

  // every input beat gives a result on the next cycle
  a_in_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  // a result taken with no new input beat leaves nothing behind
  a_no_extra : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result repeated");

  // an empty result register never blocks the input side
  a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // pending result holds while stalled
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_res)))
    else $error("stalled result changed");

  a_pready : assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready dropped");

endmodule

bind click_long_double_classifier cls_checker u_cls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_event_res (out_ch.event_res),
  .pready        (pready)
);

`default_nettype wire
